// ===== rtl/tcf_pkg.sv =====
`default_nettype none

package tcf_pkg;

    localparam int TIME_W = 48;
    localparam int DIFF_W = TIME_W + 1;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_REWIND = 2'd2,
        OP_TEST   = 2'd3
    } t_opcode;

    localparam logic CFG_WIN_START = 1'b0;
    localparam logic CFG_WIN_STOP  = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_FETCH,
        ST_EVAL,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic start_test;
        logic issue_read;
        logic capture;
        logic advance;
        logic set_hit;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic is_test;
        logic exhausted;
        logic match;
        logic later;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// ===== rtl/tcf_ram.sv =====
`default_nettype none

module tcf_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_wr_en,
    input  wire logic [AW-1:0]    i_wr_addr,
    input  wire logic [WIDTH-1:0] i_wr_data,
    input  wire logic             i_rd_en,
    input  wire logic [AW-1:0]    i_rd_addr,
    output logic      [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tcf_ctrl.sv =====
`default_nettype none

module tcf_ctrl
    import tcf_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    input  wire t_dp_status i_status,
    output t_dp_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_status.is_test) begin
                        o_cmd.start_test = 1'b1;
                        n_state          = ST_CHECK;
                    end
                end
            end
            ST_CHECK: begin
                if (i_status.exhausted) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.issue_read = 1'b1;
                    n_state          = ST_FETCH;
                end
            end
            ST_FETCH: begin
                o_cmd.capture = 1'b1;
                n_state       = ST_EVAL;
            end
            ST_EVAL: begin
                priority if (i_status.match) begin
                    o_cmd.set_hit = 1'b1;
                    n_state       = ST_DONE;
                end else if (i_status.later) begin
                    n_state = ST_DONE;
                end else begin
                    o_cmd.advance = 1'b1;
                    n_state       = ST_CHECK;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== rtl/tcf_dp.sv =====
`default_nettype none

module tcf_dp
    import tcf_pkg::*;
#(
    parameter int REF_DEPTH = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_dp_cmd           i_cmd,
    output t_dp_status             o_status,
    input  wire logic [1:0]        i_opcode,
    input  wire logic [TIME_W-1:0] i_pulse_time,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_index,
    input  wire logic [TIME_W-1:0] i_cfg_wdata,
    input  wire logic              i_out_stall,
    output logic                   o_out_valid,
    output logic                   o_keep,
    output logic                   o_ref_overflow
);

    localparam int AW = (REF_DEPTH > 1) ? $clog2(REF_DEPTH) : 1;
    localparam int CW = $clog2(REF_DEPTH + 1);

    logic signed [TIME_W-1:0] r_win_start;
    logic signed [TIME_W-1:0] r_win_stop;
    logic        [CW-1:0]     r_count;
    logic        [AW-1:0]     r_scan;
    logic                     r_ovf;
    logic        [CW-1:0]     r_idx;
    logic        [TIME_W-1:0] r_time;
    logic signed [DIFF_W-1:0] r_diff;
    logic                     r_later;
    logic                     r_hit;
    logic                     r_out_valid;
    logic                     r_keep;
    logic                     r_out_ovf;

    logic              ram_we;
    logic [TIME_W-1:0] ram_rd_data;
    logic              room;
    t_opcode           op;

    assign op   = t_opcode'(i_opcode);
    assign room = (r_count < CW'(REF_DEPTH));

    always_comb begin
        ram_we = 1'b0;
        if (i_cmd.accept && op == OP_APPEND && room) begin
            ram_we = 1'b1;
        end
    end

    tcf_ram #(
        .WIDTH (TIME_W),
        .DEPTH (REF_DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (i_pulse_time),
        .i_rd_en   (i_cmd.issue_read),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (ram_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_start <= '0;
            r_win_stop  <= '0;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_index == CFG_WIN_START) begin
                r_win_start <= i_cfg_wdata;
            end else begin
                r_win_stop <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_scan  <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                unique case (op)
                    OP_CLEAR: begin
                        r_count <= '0;
                        r_scan  <= '0;
                    end
                    OP_APPEND: begin
                        if (room) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    OP_REWIND: begin
                        r_scan <= '0;
                    end
                    OP_TEST: begin
                    end
                endcase
            end
            if (i_cmd.advance) begin
                r_scan <= r_idx[AW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_test) begin
            r_time <= i_pulse_time;
            r_idx  <= CW'(r_scan);
        end else if (i_cmd.advance) begin
            r_idx <= r_idx + CW'(1);
        end
        if (i_cmd.capture) begin
            r_diff  <= $signed({1'b0, r_time}) - $signed({1'b0, ram_rd_data});
            r_later <= (ram_rd_data > r_time);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_cmd.start_test) begin
            r_hit <= 1'b0;
        end else if (i_cmd.set_hit) begin
            r_hit <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_keep    <= r_hit;
            r_out_ovf <= r_ovf;
        end
    end

    always_comb begin
        o_status.is_test   = (op == OP_TEST);
        o_status.exhausted = (r_idx >= r_count);
        o_status.match     = (r_diff > DIFF_W'(r_win_start)) &&
                             (r_diff < DIFF_W'(r_win_stop));
        o_status.later     = r_later;
        o_status.out_free  = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid    = r_out_valid;
    assign o_keep         = r_keep;
    assign o_ref_overflow = r_out_ovf;

endmodule

`default_nettype wire

// ===== rtl/time_coincidence_filter.sv =====
`default_nettype none

// Coincidence window filter. Opcodes clear, append and rewind give no result. A test visits
// reference entries from the scan position; for each it reads the simple dual-port reference
// RAM with its registered output, forms the 49-bit difference and makes the window compare,
// ending on a match, on an entry later than the pulse or when the list runs out. A finished
// result waits in the output register, so the next transaction is accepted while it is
// stalled; a later test that finishes while that result is still stalled holds in its final
// cycle until the register drains.
// ref_overflow is sticky until reset and is not cleared by a clear opcode.

module time_coincidence_filter
    import tcf_pkg::*;
#(
    parameter int REF_DEPTH = 1024
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_opcode,
    input  wire logic [TIME_W-1:0] i_pulse_time,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic                   o_keep,
    output logic                   o_ref_overflow,
    input  wire logic              i_cfg_wr_en,
    input  wire logic              i_cfg_index,
    input  wire logic [TIME_W-1:0] i_cfg_wdata
);

    t_dp_cmd    cmd;
    t_dp_status status;

    tcf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    tcf_dp #(
        .REF_DEPTH (REF_DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_status       (status),
        .i_opcode       (i_opcode),
        .i_pulse_time   (i_pulse_time),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_keep         (o_keep),
        .o_ref_overflow (o_ref_overflow)
    );

    assign o_in_stall = !cmd.in_ready;

endmodule

`default_nettype wire

// ===== rtl/tcf_checker.sv =====
`default_nettype none

module tcf_checker
    import tcf_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              o_in_stall,
    input wire logic [1:0]        i_opcode,
    input wire logic              o_out_valid,
    input wire logic              i_out_stall,
    input wire logic              o_keep,
    input wire logic              o_ref_overflow
);

    logic r_seen_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_ovf <= 1'b0;
        end else if (o_out_valid && !i_out_stall && o_ref_overflow) begin
            r_seen_ovf <= 1'b1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_keep) && $stable(o_ref_overflow))
        else $error("stalled result changed");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && r_seen_ovf |-> o_ref_overflow)
        else $error("overflow flag dropped after being reported");

    a_test_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_opcode == OP_TEST |=> o_in_stall)
        else $error("test transaction did not hold off input");

    a_cmd_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && i_opcode != OP_TEST |=> !o_in_stall)
        else $error("buffer command did not complete in one cycle");

endmodule

bind time_coincidence_filter tcf_checker u_tcf_checker (.*);

`default_nettype wire
